[src/cfmb_pkg.sv]
package cfmb_pkg;

  // Width of one direction component, signed Q1.(DIR_BITS-1)
  localparam int DIR_BITS = 16;

  // Requantise |in_z| to Q1.15
  localparam int C_DN = (DIR_BITS > 16) ? DIR_BITS - 16 : 0;
  localparam int C_UP = (DIR_BITS < 16) ? 16 - DIR_BITS : 0;

  // Channel datapath depth in enabled cycles from cosine to value
  localparam int CH_LAT = 61;

  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 64;

  typedef enum logic [2:0] {
    REG_ETA_RED,
    REG_ETA_GREEN,
    REG_ETA_BLUE,
    REG_ABSORB_RED,
    REG_ABSORB_GREEN,
    REG_ABSORB_BLUE,
    REG_TINT_RGB,
    REG_MATCH_TOL
  } reg_idx_t;

  localparam logic [15:0] ETA_RST    = 16'd2048;
  localparam logic [15:0] ABSORB_RST = 16'd0;
  localparam logic [47:0] TINT_RST   = 48'h8000_8000_8000;
  localparam logic [7:0]  TOL_RST    = 8'd1;

endpackage

[src/cfmb_channel.sv]
module cfmb_channel
  import cfmb_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] c_in,
  input  logic [15:0] eta,
  input  logic [15:0] absorb,
  input  logic [15:0] tint,
  output logic [23:0] value
);

  localparam logic [31:0] ONE26 = 32'h0400_0000;
  localparam logic [63:0] ONE52 = 64'h0010_0000_0000_0000;

  function automatic logic [64:0] step64(input logic [63:0] rem, input logic [63:0] d);
    logic [64:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      return {1'b1, t[63:0]};
    end
    return {1'b0, t[63:0]};
  endfunction

  function automatic logic [43:0] step43(input logic [42:0] rem, input logic [42:0] d);
    logic [43:0] t;
    t = {rem, 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      return {1'b1, t[42:0]};
    end
    return {1'b0, t[42:0]};
  endfunction

  function automatic logic [49:0] step49(input logic [48:0] rem, input logic [15:0] c,
                                         input int sh);
    logic [55:0] dsh;
    logic [55:0] t;
    dsh = 56'(c) << (16 + sh);
    t = 56'(rem);
    if (t >= dsh) begin
      t = t - dsh;
      return {1'b1, t[48:0]};
    end
    return {1'b0, t[48:0]};
  endfunction

  // Stage 1: products with the cosine
  logic [31:0] ec_r, kc_r;
  logic [20:0] p2_r;
  logic [19:0] m2_r;
  logic [15:0] c1_r;
  logic [19:0] e15, k15, m2_nxt;

  // Stage 2: squares
  logic [63:0] sqm1_r, sqec_r, sqkc_r;
  logic [41:0] sqp2_r;
  logic [39:0] sqm2_r, sqk_r;
  logic [31:0] ec2_r;
  logic [15:0] c2_r;
  logic [31:0] m1;

  // Stage 3 and on: the two Fresnel quotients
  logic [63:0] r1_r [0:31];
  logic [63:0] d1_r [0:31];
  logic [42:0] r2_r [0:31];
  logic [42:0] d2_r [0:31];
  logic [31:0] q1_r [0:32];
  logic [31:0] q2_r [0:32];
  logic        ge1_r [0:32];
  logic        ge2_r [0:32];
  logic [15:0] cc_r [0:32];
  logic [64:0] st1 [0:31];
  logic [43:0] st2 [0:31];
  logic [63:0] n1, d1;
  logic [42:0] n2, d2;

  // Mean, tint product and final quotient
  logic [32:0] f_r;
  logic [15:0] cf_r;
  logic [32:0] qa, qb;
  logic [48:0] r3_r [0:23];
  logic [15:0] c3_r [0:23];
  logic [23:0] q3_r [0:24];
  logic        sat_r [1:24];
  logic [49:0] st3 [0:23];

  assign e15    = {eta, 4'b0};
  assign k15    = {absorb, 4'b0};
  assign m2_nxt = (e15 >= 20'(c_in)) ? e15 - 20'(c_in) : 20'(c_in) - e15;
  assign m1     = (ec_r >= ONE26) ? ec_r - ONE26 : ONE26 - ec_r;

  assign n1 = sqm1_r + sqkc_r;
  assign d1 = sqec_r + {5'b0, ec2_r, 27'b0} + ONE52 + sqkc_r;
  assign n2 = 43'(sqm2_r) + 43'(sqk_r);
  assign d2 = 43'(sqp2_r) + 43'(sqk_r);

  assign qa = ge1_r[32] ? 33'h1_0000_0000 : {1'b0, q1_r[32]};
  assign qb = ge2_r[32] ? 33'h1_0000_0000 : {1'b0, q2_r[32]};

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      st1[i] = step64(r1_r[i], d1_r[i]);
      st2[i] = step43(r2_r[i], d2_r[i]);
    end
    for (int i = 0; i < 24; i++) begin
      st3[i] = step49(r3_r[i], c3_r[i], 23 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ec_r   <= 32'(eta) * 32'(c_in);
      kc_r   <= 32'(absorb) * 32'(c_in);
      p2_r   <= 21'(e15) + 21'(c_in);
      m2_r   <= m2_nxt;
      c1_r   <= c_in;

      sqm1_r <= 64'(m1) * 64'(m1);
      sqec_r <= 64'(ec_r) * 64'(ec_r);
      sqkc_r <= 64'(kc_r) * 64'(kc_r);
      sqp2_r <= 42'(p2_r) * 42'(p2_r);
      sqm2_r <= 40'(m2_r) * 40'(m2_r);
      sqk_r  <= 40'(k15) * 40'(k15);
      ec2_r  <= ec_r;
      c2_r   <= c1_r;

      r1_r[0]  <= n1;
      d1_r[0]  <= d1;
      r2_r[0]  <= n2;
      d2_r[0]  <= d2;
      q1_r[0]  <= '0;
      q2_r[0]  <= '0;
      ge1_r[0] <= (n1 >= d1);
      ge2_r[0] <= (n2 >= d2);
      cc_r[0]  <= c2_r;
      for (int i = 0; i < 31; i++) begin
        r1_r[i+1] <= st1[i][63:0];
        d1_r[i+1] <= d1_r[i];
        r2_r[i+1] <= st2[i][42:0];
        d2_r[i+1] <= d2_r[i];
      end
      for (int i = 0; i < 32; i++) begin
        q1_r[i+1]  <= {q1_r[i][30:0], st1[i][64]};
        q2_r[i+1]  <= {q2_r[i][30:0], st2[i][43]};
        ge1_r[i+1] <= ge1_r[i];
        ge2_r[i+1] <= ge2_r[i];
        cc_r[i+1]  <= cc_r[i];
      end

      f_r  <= 33'((34'(qa) + 34'(qb)) >> 1);
      cf_r <= cc_r[32];

      r3_r[0] <= 49'(f_r) * 49'(tint);
      c3_r[0] <= cf_r;
      q3_r[0] <= '0;
      sat_r[1] <= (56'(r3_r[0]) >= {c3_r[0], 40'b0});
      for (int i = 1; i < 24; i++) begin
        sat_r[i+1] <= sat_r[i];
      end
      for (int i = 0; i < 23; i++) begin
        r3_r[i+1] <= st3[i][48:0];
        c3_r[i+1] <= c3_r[i];
      end
      for (int i = 0; i < 24; i++) begin
        q3_r[i+1] <= {q3_r[i][22:0], st3[i][49]};
      end
    end
  end

  assign value = sat_r[24] ? 24'hFF_FFFF : q3_r[24];

endmodule

[src/conductor_fresnel_mirror_brdf.sv]
// Conductor mirror BRDF evaluator.
// Input channel: one beat carries an outgoing and an incoming direction (signed Q1.15
// components). in_valid/in_stall handshake; a beat is taken when valid is high and stall low.
// Result channel: one beat per input beat, in order, with three Q8.16 saturating colour
// values and is_mirror. Non-mirror beats come out black with is_mirror low.
// Pipeline: entry registers, the two 32-step Fresnel quotient chains and the 24-step cosine
// divide, each one bit per pipeline stage, then the output register. Throughput: one beat
// per cycle while the skid register is empty; a held skid beat stalls the input.
// Configuration: APB writes at byte address 8*index, data 64 bits, pready always high.
// Write registers only while no beats are in flight.
// Reset (synchronous, rst_n low): empty the pipeline and load the register defaults.
// Stall: a skid register behind the output register takes the beat that leaves the pipeline
// while the output beat is stalled; while the skid holds a beat the whole pipeline freezes and
// in_stall is high. Nothing is dropped or repeated.
module conductor_fresnel_mirror_brdf
  import cfmb_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [DIR_BITS-1:0]  in_out_x,
  input  logic signed [DIR_BITS-1:0]  in_out_y,
  input  logic signed [DIR_BITS-1:0]  in_out_z,
  input  logic signed [DIR_BITS-1:0]  in_in_x,
  input  logic signed [DIR_BITS-1:0]  in_in_y,
  input  logic signed [DIR_BITS-1:0]  in_in_z,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [23:0]                 out_value_red,
  output logic [23:0]                 out_value_green,
  output logic [23:0]                 out_value_blue,
  output logic                        out_is_mirror,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_BITS-1:0]        paddr,
  input  logic [DATA_BITS-1:0]        pwdata,
  output logic [DATA_BITS-1:0]        prdata,
  output logic                        pready
);

  // Configuration registers
  logic [15:0] eta_r [0:2];
  logic [15:0] absorb_r [0:2];
  logic [47:0] tint_r;
  logic [7:0]  tol_r;
  logic        cfg_wr;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        eta_r[i]    <= ETA_RST;
        absorb_r[i] <= ABSORB_RST;
      end
      tint_r <= TINT_RST;
      tol_r  <= TOL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ETA_RED:      eta_r[0]    <= pwdata[15:0];
        REG_ETA_GREEN:    eta_r[1]    <= pwdata[15:0];
        REG_ETA_BLUE:     eta_r[2]    <= pwdata[15:0];
        REG_ABSORB_RED:   absorb_r[0] <= pwdata[15:0];
        REG_ABSORB_GREEN: absorb_r[1] <= pwdata[15:0];
        REG_ABSORB_BLUE:  absorb_r[2] <= pwdata[15:0];
        REG_TINT_RGB:     tint_r      <= pwdata[47:0];
        REG_MATCH_TOL:    tol_r       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ETA_RED:      prdata = 64'(eta_r[0]);
      REG_ETA_GREEN:    prdata = 64'(eta_r[1]);
      REG_ETA_BLUE:     prdata = 64'(eta_r[2]);
      REG_ABSORB_RED:   prdata = 64'(absorb_r[0]);
      REG_ABSORB_GREEN: prdata = 64'(absorb_r[1]);
      REG_ABSORB_BLUE:  prdata = 64'(absorb_r[2]);
      REG_TINT_RGB:     prdata = 64'(tint_r);
      REG_MATCH_TOL:    prdata = 64'(tol_r);
      default:          prdata = '0;
    endcase
  end

  // Pipeline advances unless the skid register holds a beat
  logic skid_v_r;
  logic en;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Entry stage: mirror test against (-out_x, -out_y, out_z) and cosine requantisation
  logic signed [DIR_BITS:0] sum_x, sum_y, dif_z, iz_w;
  logic [DIR_BITS:0]        mag_x, mag_y, mag_z, tol_w, cin_w;
  logic [47:0]              cwide;
  logic [15:0]              cq, c_nxt;
  logic                     match_nxt;

  assign sum_x = (DIR_BITS+1)'(in_in_x) + (DIR_BITS+1)'(in_out_x);
  assign sum_y = (DIR_BITS+1)'(in_in_y) + (DIR_BITS+1)'(in_out_y);
  assign dif_z = (DIR_BITS+1)'(in_in_z) - (DIR_BITS+1)'(in_out_z);
  assign iz_w  = (DIR_BITS+1)'(in_in_z);

  assign mag_x = sum_x[DIR_BITS] ? $unsigned(-sum_x) : $unsigned(sum_x);
  assign mag_y = sum_y[DIR_BITS] ? $unsigned(-sum_y) : $unsigned(sum_y);
  assign mag_z = dif_z[DIR_BITS] ? $unsigned(-dif_z) : $unsigned(dif_z);
  assign cin_w = iz_w[DIR_BITS]  ? $unsigned(-iz_w)  : $unsigned(iz_w);
  assign tol_w = (DIR_BITS+1)'(tol_r);

  assign match_nxt = (mag_x < tol_w) && (mag_y < tol_w) && (mag_z < tol_w);

  // Floor the cosine at one LSB
  assign cwide = (48'(cin_w) >> C_DN) << C_UP;
  assign cq    = cwide[15:0];
  assign c_nxt = (cq == 16'd0) ? 16'd1 : cq;

  // Valid and match bits travel alongside the channel datapaths
  logic        vld_r [0:CH_LAT];
  logic        mat_r [0:CH_LAT];
  logic [15:0] ca_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CH_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 0; i < CH_LAT; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r[0] <= match_nxt;
      ca_r     <= c_nxt;
      for (int i = 0; i < CH_LAT; i++) begin
        mat_r[i+1] <= mat_r[i];
      end
    end
  end

  // One Fresnel/tint/cosine datapath per colour; tint red sits in the top bits
  logic [23:0] val_ch [0:2];

  cfmb_channel u_red (
    .clk    (clk),
    .en     (en),
    .c_in   (ca_r),
    .eta    (eta_r[0]),
    .absorb (absorb_r[0]),
    .tint   (tint_r[47:32]),
    .value  (val_ch[0])
  );

  cfmb_channel u_green (
    .clk    (clk),
    .en     (en),
    .c_in   (ca_r),
    .eta    (eta_r[1]),
    .absorb (absorb_r[1]),
    .tint   (tint_r[31:16]),
    .value  (val_ch[1])
  );

  cfmb_channel u_blue (
    .clk    (clk),
    .en     (en),
    .c_in   (ca_r),
    .eta    (eta_r[2]),
    .absorb (absorb_r[2]),
    .tint   (tint_r[15:0]),
    .value  (val_ch[2])
  );

  // Black out beats that failed the mirror test
  logic [23:0] res_r, res_g, res_b;
  logic        res_m;

  assign res_m = mat_r[CH_LAT];
  assign res_r = res_m ? val_ch[0] : 24'd0;
  assign res_g = res_m ? val_ch[1] : 24'd0;
  assign res_b = res_m ? val_ch[2] : 24'd0;

  // Output register plus skid register
  logic        out_valid_r;
  logic [23:0] out_red_r, out_green_r, out_blue_r;
  logic        out_mir_r;
  logic [23:0] skid_red_r, skid_green_r, skid_blue_r;
  logic        skid_mir_r;
  logic        out_take;

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      // Drain the skid beat once the output beat is taken
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= vld_r[CH_LAT];
    end else if (vld_r[CH_LAT]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_red_r   <= skid_red_r;
        out_green_r <= skid_green_r;
        out_blue_r  <= skid_blue_r;
        out_mir_r   <= skid_mir_r;
      end
    end else if (!out_valid_r || out_take) begin
      out_red_r   <= res_r;
      out_green_r <= res_g;
      out_blue_r  <= res_b;
      out_mir_r   <= res_m;
    end else begin
      skid_red_r   <= res_r;
      skid_green_r <= res_g;
      skid_blue_r  <= res_b;
      skid_mir_r   <= res_m;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_red   = out_red_r;
  assign out_value_green = out_green_r;
  assign out_value_blue  = out_blue_r;
  assign out_is_mirror   = out_mir_r;

endmodule
